[hdl/custom_base_text_to_integer_assert.svh]
// Assertion macros for the checker file of the text-to-integer converter.
`ifndef CUSTOM_BASE_TEXT_TO_INTEGER_ASSERT_SVH
`define CUSTOM_BASE_TEXT_TO_INTEGER_ASSERT_SVH

// same-cycle implication
`define CTBI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("custom_base_text_to_integer: assertion failed");

// next-cycle implication
`define CTBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("custom_base_text_to_integer: assertion failed");

`endif

[hdl/ctbi_pkg.sv]
// Shared constants, types and helpers of the text-to-integer converter.
package ctbi_pkg;

    localparam int MAX_RADIX_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_VALUE_W    = 64;
    localparam int NUMBER_W       = 32;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 8;
    localparam int ALPHA_CHARS    = 16;
    localparam int ALPHA_W        = ALPHA_CHARS * CHAR_W;
    localparam int DIGIT_W        = 4;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]    RADIX_RST      = 5'd10;
    localparam logic [CFG_DATA_W-1:0] ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [ALPHA_W-1:0] alphabet;
        logic               base_ok;
    } cfg_t;

    typedef struct packed {
        logic               last;
        logic               space;
        logic               sign;
        logic               minus;
        logic               digit_hit;
        logic [DIGIT_W-1:0] digit;
    } class_t;

    function automatic logic [CHAR_W-1:0] char_at(input logic [ALPHA_W-1:0] alpha,
                                                  input int unsigned pos);
        return alpha[pos*CHAR_W +: CHAR_W];
    endfunction

endpackage

[hdl/ctbi_cfg.sv]
// Configuration registers and registered alphabet validity check.
module ctbi_cfg #(
    parameter int MAX_RADIX = ctbi_pkg::MAX_RADIX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctbi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ctbi_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ctbi_pkg::cfg_t                     cfg
);

    logic [ctbi_pkg::RADIX_W-1:0]    radix_reg;
    logic [ctbi_pkg::CFG_DATA_W-1:0] alpha_low_reg;
    logic [ctbi_pkg::CFG_DATA_W-1:0] alpha_high_reg;
    logic                            ok_reg;
    logic                            ok_next;
    logic [ctbi_pkg::ALPHA_W-1:0]    alpha;

    assign cfg_ready = 1'b1;
    assign alpha     = {alpha_high_reg, alpha_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= ctbi_pkg::RADIX_RST;
            alpha_low_reg  <= ctbi_pkg::ALPHA_LOW_RST;
            alpha_high_reg <= ctbi_pkg::ALPHA_HIGH_RST;
            ok_reg         <= 1'b0;
        end else begin
            ok_reg <= ok_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    ctbi_pkg::REG_RADIX:      radix_reg      <= cfg_data[ctbi_pkg::RADIX_W-1:0];
                    ctbi_pkg::REG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                    ctbi_pkg::REG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // radix range check, then forbidden characters and a pairwise compare over the used positions
    always_comb begin
        logic [ctbi_pkg::CHAR_W-1:0] ci;
        ok_next = (radix_reg >= ctbi_pkg::RADIX_W'(2))
               && (radix_reg <= ctbi_pkg::RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            ci = ctbi_pkg::char_at(alpha, i);
            if (ctbi_pkg::RADIX_W'(i) < radix_reg) begin
                if (ci == ctbi_pkg::CH_NUL || ci == ctbi_pkg::CH_PLUS
                        || ci == ctbi_pkg::CH_MINUS) begin
                    ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (ctbi_pkg::RADIX_W'(j) < radix_reg
                            && ctbi_pkg::char_at(alpha, j) == ci) begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    assign cfg.radix    = radix_reg;
    assign cfg.alphabet = alpha;
    assign cfg.base_ok  = ok_reg;

endmodule

[hdl/ctbi_front.sv]
// Input handshake and byte classification (whitespace, sign, digit lookup).
module ctbi_front #(
    parameter int MAX_RADIX = ctbi_pkg::MAX_RADIX_DEF
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ctbi_pkg::CHAR_W-1:0]   s_text_byte,
    input  logic                          s_end_of_text,
    input  ctbi_pkg::cfg_t                cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output ctbi_pkg::class_t              q_word
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        logic [ctbi_pkg::CHAR_W-1:0] b;
        b = s_text_byte;
        q_word       = '0;
        q_word.last  = s_end_of_text;
        q_word.space = (b == ctbi_pkg::CH_TAB) || (b == ctbi_pkg::CH_VT)
                    || (b == ctbi_pkg::CH_CR)  || (b == ctbi_pkg::CH_LF)
                    || (b == ctbi_pkg::CH_FF)  || (b == ctbi_pkg::CH_SPACE);
        q_word.sign  = (b == ctbi_pkg::CH_PLUS) || (b == ctbi_pkg::CH_MINUS);
        q_word.minus = (b == ctbi_pkg::CH_MINUS);
        // lowest matching position wins
        for (int i = MAX_RADIX - 1; i >= 0; i--) begin
            if (b != ctbi_pkg::CH_NUL && ctbi_pkg::RADIX_W'(i) < cfg.radix
                    && ctbi_pkg::char_at(cfg.alphabet, i) == b) begin
                q_word.digit_hit = 1'b1;
                q_word.digit     = ctbi_pkg::DIGIT_W'(i);
            end
        end
    end

endmodule

[hdl/ctbi_queue.sv]
// Short FIFO of classified words between front and back.
module ctbi_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ctbi_pkg::class_t  push_word,
    input  logic              pop,
    output ctbi_pkg::class_t  head_word,
    output logic              not_empty,
    output logic              full
);

    localparam int DEPTH = ctbi_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctbi_pkg::class_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[hdl/ctbi_back.sv]
// Parse state machine, multiply-accumulate and output register.
module ctbi_back #(
    parameter int VALUE_BITS = ctbi_pkg::VALUE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  ctbi_pkg::class_t                     q_word,
    output logic                                 q_pop,
    input  ctbi_pkg::cfg_t                       cfg,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ctbi_pkg::NUMBER_W-1:0] m_number,
    output logic                                 m_alphabet_ok
);

    localparam int MAC_W = VALUE_BITS + ctbi_pkg::RADIX_W;

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [1:0]            acc_phase;
    logic                  acc_neg;
    logic [VALUE_BITS-1:0] acc_value;
    logic [MAC_W-1:0]      mac;

    logic                  out_valid_reg;
    logic                  out_neg_reg;
    logic                  out_ok_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    logic [VALUE_BITS-1:0]           signed_value;
    logic [VALUE_BITS-1:0]           result_value;
    logic [ctbi_pkg::MAX_VALUE_W-1:0] result_wide;

    assign q_pop = q_valid && (!q_word.last || !out_valid_reg || m_ready);

    assign mac = MAC_W'(value_reg) * MAC_W'(cfg.radix) + MAC_W'(q_word.digit);

    always_comb begin
        acc_phase = phase_reg;
        acc_neg   = neg_reg;
        acc_value = value_reg;
        unique case (phase_reg)
            PH_SPACE: begin
                if (q_word.space) begin
                    acc_phase = PH_SPACE;
                end else if (q_word.sign) begin
                    acc_neg   = q_word.minus;
                    acc_phase = PH_DIGITS;
                end else if (q_word.digit_hit) begin
                    acc_value = mac[VALUE_BITS-1:0];
                    acc_phase = PH_DIGITS;
                end else begin
                    acc_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (q_word.digit_hit) begin
                    acc_value = mac[VALUE_BITS-1:0];
                end else begin
                    acc_phase = PH_DONE;
                end
            end
            PH_DONE: ;
            default: acc_phase = PH_DONE;
        endcase

        phase_next = phase_reg;
        neg_next   = neg_reg;
        value_next = value_reg;
        if (q_pop) begin
            if (q_word.last) begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                value_next = '0;
            end else begin
                phase_next = acc_phase;
                neg_next   = acc_neg;
                value_next = acc_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            value_reg <= value_next;
            if (q_pop && q_word.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_word.last) begin
            out_value_reg <= acc_value;
            out_neg_reg   <= acc_neg;
            out_ok_reg    <= cfg.base_ok;
        end
    end

    assign signed_value  = out_neg_reg ? ('0 - out_value_reg) : out_value_reg;
    assign result_value  = out_ok_reg ? signed_value : '0;
    assign result_wide   = ctbi_pkg::MAX_VALUE_W'(result_value);
    assign m_valid       = out_valid_reg;
    assign m_number      = signed'(result_wide[ctbi_pkg::NUMBER_W-1:0]);
    assign m_alphabet_ok = out_ok_reg;

endmodule

[hdl/custom_base_text_to_integer.sv]
// Text-to-integer converter with a configurable digit alphabet, top level.
// The result of the final byte passes through the queue and the output register to m_.
// Throughput: one byte per cycle unless a final byte waits at the queue head behind a held result.
// A two-word queue lets the input run on while a result waits on m_ready, until the next final byte reaches its head.
// Reset (aresetn low, synchronous) empties the pipe and restores radix 10, digits "0"-"9".
module custom_base_text_to_integer #(
    parameter int MAX_RADIX  = ctbi_pkg::MAX_RADIX_DEF,
    parameter int VALUE_BITS = ctbi_pkg::VALUE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ctbi_pkg::CHAR_W-1:0]          s_text_byte,
    input  logic                                 s_end_of_text,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ctbi_pkg::NUMBER_W-1:0] m_number,
    output logic                                 m_alphabet_ok,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctbi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ctbi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ctbi_pkg::cfg_t   cfg;
    ctbi_pkg::class_t push_word;
    ctbi_pkg::class_t head_word;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;

    ctbi_cfg #(.MAX_RADIX(MAX_RADIX)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctbi_front #(.MAX_RADIX(MAX_RADIX)) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_word        (push_word)
    );

    ctbi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (push_word),
        .pop       (q_pop),
        .head_word (head_word),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    ctbi_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_word        (head_word),
        .q_pop         (q_pop),
        .cfg           (cfg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_number      (m_number),
        .m_alphabet_ok (m_alphabet_ok)
    );

endmodule

[hdl/ctbi_checker.sv]
// Port-level assertions for the text-to-integer converter, bound to the top level.
`include "custom_base_text_to_integer_assert.svh"

module ctbi_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [ctbi_pkg::NUMBER_W-1:0] m_number,
    input logic                                 m_alphabet_ok
);

    // held result word stays put
    `CTBI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_number) && $stable(m_alphabet_ok))

    // bad alphabet always reads as zero
    `CTBI_ASSERT_IMPL(a_bad_base_zero, aclk, aresetn, m_valid && !m_alphabet_ok, m_number == '0)

    // input only backs up behind a result that is waiting
    `CTBI_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, m_valid)

endmodule

bind custom_base_text_to_integer ctbi_checker u_checker (.*);

[verif/custom_base_text_to_integer_tb.sv]
// Self-checking testbench of the custom-alphabet text-to-integer converter.
`timescale 1ns / 100ps

module custom_base_text_to_integer_tb;
    import ctbi_pkg::*;

    localparam int ITEMS_TOTAL  = 1250;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 16;
    localparam int PRINT_CAP    = 40;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    typedef enum logic [1:0] {SKIP_SPACE, IN_DIGITS, PAST_DIGITS} parse_phase_e;
    typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic                ok;
    } result_t;

    typedef struct {
        int unsigned         seq;
        logic [NUMBER_W-1:0] number;
        logic                ok;
    } answer_t;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [CHAR_W-1:0]      ch;
        logic                   last;
        logic                   typed;
        logic [NUMBER_W-1:0]    number;
        logic                   ok;
    } row_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [CHAR_W-1:0]             s_text_byte   = '0;
    logic                          s_end_of_text = 1'b0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic signed [NUMBER_W-1:0]    m_number;
    logic                          m_alphabet_ok;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index     = '0;
    logic [CFG_DATA_W-1:0]         cfg_data      = '0;

    // predictor state
    logic [RADIX_W-1:0]    cfg_radix;
    logic [CFG_DATA_W-1:0] cfg_lo;
    logic [CFG_DATA_W-1:0] cfg_hi;
    parse_phase_e          phase;
    logic                  neg;
    logic [NUMBER_W-1:0]   acc;

    result_t     due_results [$];
    answer_t     fixed_answers [$];
    int unsigned words_in   = 0;
    int unsigned words_out  = 0;
    int          burst_left = 0;
    int          hold_req   = 0;
    int          mismatches = 0;

    custom_base_text_to_integer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_number      (m_number),
        .m_alphabet_ok (m_alphabet_ok),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] char_of(input int pos);
        return (pos < 8) ? cfg_lo[pos*CHAR_W +: CHAR_W] : cfg_hi[(pos-8)*CHAR_W +: CHAR_W];
    endfunction

    function automatic bit is_blank(input logic [CHAR_W-1:0] b);
        return b == CH_TAB || b == CH_VT || b == CH_CR || b == CH_LF ||
               b == CH_FF || b == CH_SPACE;
    endfunction

    function automatic bit base_ok();
        int n;
        logic [CHAR_W-1:0] c;
        if (cfg_radix < 2 || cfg_radix > MAX_RADIX_DEF) return 1'b0;
        n = cfg_radix;
        for (int i = 0; i < n; i++) begin
            c = char_of(i);
            if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS) return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (char_of(j) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_pos(input logic [CHAR_W-1:0] b);
        int n;
        n = (cfg_radix > MAX_RADIX_DEF) ? MAX_RADIX_DEF : cfg_radix;
        if (b == CH_NUL) return -1;
        for (int i = 0; i < n; i++)
            if (char_of(i) == b) return i;
        return -1;
    endfunction

    function automatic void absorb_digit(input logic [CHAR_W-1:0] b);
        int d;
        d = digit_pos(b);
        if (d < 0) begin
            phase = PAST_DIGITS;
        end else begin
            acc   = acc * NUMBER_W'(cfg_radix) + NUMBER_W'(d);
            phase = IN_DIGITS;
        end
    endfunction

    // advances the parse by one word; returns 1 when a result is due
    function automatic bit convert_char(input logic [CHAR_W-1:0] b, input logic last,
                                        output logic [NUMBER_W-1:0] number,
                                        output logic ok);
        number = '0;
        ok     = 1'b0;
        case (phase)
            SKIP_SPACE: begin
                if (b == CH_MINUS || b == CH_PLUS) begin
                    neg   = (b == CH_MINUS);
                    phase = IN_DIGITS;
                end else if (!is_blank(b)) begin
                    absorb_digit(b);
                end
            end
            IN_DIGITS: absorb_digit(b);
            default: ;
        endcase
        if (!last) return 1'b0;
        ok     = base_ok();
        number = ok ? (neg ? -acc : acc) : '0;
        phase  = SKIP_SPACE;
        neg    = 1'b0;
        acc    = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [NUMBER_W-1:0] got,
                                 input logic [NUMBER_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH %s: got %08h, want %08h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin : scoreboard
        logic [NUMBER_W-1:0] number;
        logic                ok;
        result_t             r;
        if (!aresetn) begin
            cfg_radix = RADIX_RST;
            cfg_lo    = ALPHA_LOW_RST;
            cfg_hi    = ALPHA_HIGH_RST;
            phase     = SKIP_SPACE;
            neg       = 1'b0;
            acc       = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RADIX:      cfg_radix = cfg_data[RADIX_W-1:0];
                    REG_ALPHA_LOW:  cfg_lo    = cfg_data;
                    REG_ALPHA_HIGH: cfg_hi    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (convert_char(s_text_byte, s_end_of_text, number, ok)) begin
                    if (fixed_answers.size() != 0 && fixed_answers[0].seq == words_in) begin
                        number = fixed_answers[0].number;
                        ok     = fixed_answers[0].ok;
                        void'(fixed_answers.pop_front());
                    end
                    r.number = number;
                    r.ok     = ok;
                    due_results.push_back(r);
                end
                words_in++;
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected result", m_number, '0);
                end else begin
                    r = due_results.pop_front();
                    if (m_number !== r.number) flag_mismatch("number", m_number, r.number);
                    if (m_alphabet_ok !== r.ok)
                        flag_mismatch("alphabet_ok", NUMBER_W'(m_alphabet_ok), NUMBER_W'(r.ok));
                end
            end
        end
    end

    // result side: stall pattern of its own, plus long hold-offs on request
    initial begin : receiver
        int style;
        int span;
        int hold;
        span = 0;
        hold = 0;
        style = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != 0) begin
                hold     = hold_req;
                hold_req = 0;
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
            end
            span--;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (span % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= last;
        words_out++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender pauses until every result is back and the pipe is empty
    task automatic settle();
        s_valid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic choose_setting();
        logic [CHAR_W-1:0]     chars [16];
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] junk;
        logic [RADIX_W-1:0]    r;
        logic [CHAR_W-1:0]     c;
        bit                    clash;
        int                    style;
        int                    i;
        int                    j;
        int                    start;
        style = $urandom_range(0, 9);
        for (i = 0; i < 16; i++) begin
            do begin
                c     = 8'($urandom_range(1, 255));
                clash = (c == CH_PLUS || c == CH_MINUS) ||
                        (is_blank(c) && $urandom_range(0, 7) != 0);
                for (j = 0; j < i; j++)
                    if (chars[j] == c) clash = 1'b1;
            end while (clash);
            chars[i] = c;
        end
        r = 5'($urandom_range(2, 16));
        case (style)
            0, 1: begin
                for (i = 0; i < 16; i++)
                    chars[i] = (i < 10) ? 8'h30 + 8'(i) : 8'h61 + 8'(i - 10);
                r = (style == 0) ? 5'd10 : 5'd16;
            end
            6: begin
                i = $urandom_range(0, r - 2);
                j = $urandom_range(i + 1, r - 1);
                chars[j] = chars[i];
            end
            7: begin
                case ($urandom_range(0, 2))
                    0:       c = CH_PLUS;
                    1:       c = CH_MINUS;
                    default: c = CH_NUL;
                endcase
                chars[$urandom_range(0, r - 1)] = c;
            end
            8: begin
                case ($urandom_range(0, 2))
                    0:       r = 5'd0;
                    1:       r = 5'd1;
                    default: r = 5'($urandom_range(17, 31));
                endcase
            end
            9: begin
                for (i = 0; i < 16; i++) chars[i] = 8'($urandom_range(0, 255));
                r = 5'($urandom_range(0, 31));
            end
            default: ;
        endcase
        for (i = 0; i < 8; i++) begin
            lo[i*CHAR_W +: CHAR_W] = chars[i];
            hi[i*CHAR_W +: CHAR_W] = chars[i+8];
        end
        junk  = {$urandom, $urandom};
        start = $urandom_range(0, 2);
        for (i = 0; i < 3; i++) begin
            case ((start + i) % 3)
                0:       write_reg(REG_RADIX, {junk[CFG_DATA_W-1:RADIX_W], r});
                1:       write_reg(REG_ALPHA_LOW, lo);
                default: write_reg(REG_ALPHA_HIGH, hi);
            endcase
        end
        if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, {$urandom, $urandom});
    endtask

    // mostly well-formed numbers in the current alphabet, some noise and cut-offs
    task automatic send_text();
        logic [CHAR_W-1:0] text [$];
        logic [CHAR_W-1:0] blanks [6];
        int kind;
        int used;
        int cut;
        blanks = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};
        kind = $urandom_range(0, 9);
        used = (cfg_radix > MAX_RADIX_DEF) ? MAX_RADIX_DEF : cfg_radix;
        if (kind == 0 || used == 0) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) text.push_back(blanks[$urandom_range(0, 5)]);
            case ($urandom_range(0, 3))
                0:       text.push_back(CH_MINUS);
                1:       text.push_back(CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 12))
                text.push_back(char_of(int'($urandom_range(0, used - 1))));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
            if (kind == 1 && text.size() > 1) begin
                cut = $urandom_range(1, text.size() - 1);
                while (text.size() > cut) void'(text.pop_back());
            end
        end
        if (text.size() == 0) text.push_back(blanks[$urandom_range(0, 5)]);
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    function automatic row_t ch(input logic [CHAR_W-1:0] b);
        row_t t;
        t = '{ROW_CHAR, REG_RADIX, '0, b, 1'b0, 1'b0, '0, 1'b0};
        return t;
    endfunction

    function automatic row_t fin(input logic [CHAR_W-1:0] b);
        row_t t;
        t = '{ROW_CHAR, REG_RADIX, '0, b, 1'b1, 1'b0, '0, 1'b0};
        return t;
    endfunction

    function automatic row_t fin_is(input logic [CHAR_W-1:0] b,
                                    input logic [NUMBER_W-1:0] number, input logic ok);
        row_t t;
        t = '{ROW_CHAR, REG_RADIX, '0, b, 1'b1, 1'b1, number, ok};
        return t;
    endfunction

    function automatic row_t wr(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        row_t t;
        t = '{ROW_REG, idx, data, '0, 1'b0, 1'b0, '0, 1'b0};
        return t;
    endfunction

    initial begin : stimulus
        row_t    plan [$];
        answer_t a;
        int      next_switch;
        plan = '{
            fin_is("7", 32'd7, 1'b1),
            ch(CH_SPACE), ch(CH_TAB), ch(CH_LF), ch(CH_VT), ch(CH_FF), ch(CH_CR),
            ch(CH_MINUS), ch("4"), fin_is("2", -32'sd42, 1'b1),
            fin_is(CH_PLUS, 32'd0, 1'b1),
            fin_is(CH_NUL, 32'd0, 1'b1),
            ch("9"), ch(8'hFF), fin_is("5", 32'd9, 1'b1),
            wr(REG_NONE, '1),
            wr(REG_RADIX, 64'd31),
            fin_is("5", 32'd0, 1'b0),
            wr(REG_RADIX, 64'd0),
            fin_is("5", 32'd0, 1'b0),
            wr(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFF0),
            wr(REG_ALPHA_HIGH, 64'h6665_6463_6261_3938),
            ch("f"), ch("f"), ch("f"), ch("f"), ch("f"), ch("f"), ch("f"),
            fin_is("f", 32'hFFFF_FFFF, 1'b1),
            ch("1"), ch("0"),
            wr(REG_RADIX, 64'd10),
            fin("1"),
            wr(REG_ALPHA_LOW, 64'h3736_3534_3332_3030),
            fin_is("0", 32'd0, 1'b0),
            wr(REG_ALPHA_LOW, ALPHA_LOW_RST)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (plan[i].typed) begin
                    a.seq    = words_out;
                    a.number = plan[i].number;
                    a.ok     = plan[i].ok;
                    fixed_answers.push_back(a);
                end
                send_char(plan[i].ch, plan[i].last);
            end
        end

        // back-pressure: results held off while single-digit strings keep coming
        settle();
        hold_req = 300;
        repeat (16) send_char(8'h30 + 8'($urandom_range(0, 9)), 1'b1);
        settle();

        next_switch = words_out;
        while (words_out < ITEMS_TOTAL) begin
            if (words_out >= next_switch) begin
                choose_setting();
                next_switch = words_out + $urandom_range(60, 160);
                if ($urandom_range(0, 3) == 0) hold_req = $urandom_range(40, 200);
            end
            send_text();
        end

        settle();
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
